/* rtl/core/sag_pkg.sv */
// Shared types, constants and ray geometry for the sliding attack generator.
package sag_pkg;

   localparam int unsigned RayCount    = 4;
   localparam int unsigned RayLength   = 7;
   localparam int unsigned SquareWidth = 6;
   localparam int unsigned BoardWidth  = 64;
   localparam int unsigned RayWidth    = $clog2(RayCount);
   localparam int unsigned StepWidth   = $clog2(RayLength + 1);
   localparam int unsigned CoordWidth  = SquareWidth / 2;
   localparam int unsigned OffsetWidth = CoordWidth + 2;

   typedef enum logic {
      PIECE_ROOK   = 1'b0,
      PIECE_BISHOP = 1'b1
   } piece_type;

   typedef logic [RayCount-1:0][RayLength-1:0] ray_bits_type;

   typedef struct packed {
      logic                   ok;
      logic [SquareWidth-1:0] index;
   } ray_square_type;

   typedef struct packed {
      piece_type              piece;
      logic [SquareWidth-1:0] square;
      ray_bits_type           on_board;
      ray_bits_type           occupied;
   } gather_type;

   typedef struct packed {
      piece_type              piece;
      logic [SquareWidth-1:0] square;
      ray_bits_type           reached;
   } scan_type;

   // For a rook, the upper ray bit picks the file axis and the lower bit the negative
   // direction. For a bishop, the upper bit sends the rank down and the lower bit the file.
   function automatic ray_square_type ray_square(piece_type piece,
                                                 logic [RayWidth-1:0] ray,
                                                 logic [StepWidth-1:0] step,
                                                 logic [SquareWidth-1:0] square);
      logic [OffsetWidth-1:0] rank_same;
      logic [OffsetWidth-1:0] rank_up;
      logic [OffsetWidth-1:0] rank_down;
      logic [OffsetWidth-1:0] file_same;
      logic [OffsetWidth-1:0] file_up;
      logic [OffsetWidth-1:0] file_down;
      logic [OffsetWidth-1:0] rank_next;
      logic [OffsetWidth-1:0] file_next;
      ray_square_type         result;
      rank_same = {2'b00, square[SquareWidth-1:CoordWidth]};
      file_same = {2'b00, square[CoordWidth-1:0]};
      rank_up   = rank_same + OffsetWidth'(step);
      rank_down = rank_same - OffsetWidth'(step);
      file_up   = file_same + OffsetWidth'(step);
      file_down = file_same - OffsetWidth'(step);
      if (piece == PIECE_BISHOP) begin
         rank_next = ray[1] ? rank_down : rank_up;
         file_next = ray[0] ? file_down : file_up;
      end else begin
         rank_next = ray[1] ? rank_same : (ray[0] ? rank_down : rank_up);
         file_next = ray[1] ? (ray[0] ? file_down : file_up) : file_same;
      end
      result.ok    = (rank_next[OffsetWidth-1:CoordWidth] == 2'b00) &&
                     (file_next[OffsetWidth-1:CoordWidth] == 2'b00);
      result.index = {rank_next[CoordWidth-1:0], file_next[CoordWidth-1:0]};
      return result;
   endfunction

endpackage

/* rtl/core/sliding_attack_generator.sv */
// Top level of the sliding attack generator: three pipeline stages from request to response.
// The stages gather, scan and scatter the four rays; a request passes each register in turn to rsp_valid.
// Throughput is one request per cycle while the response is not stalled.
// A stalled response holds back only as many stages as are full, so nothing is lost.
// Synchronous reset clears the valid bit of every stage; the data registers are not reset.
module sliding_attack_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [sag_pkg::SquareWidth-1:0] req_square,
   input  logic [sag_pkg::BoardWidth-1:0] req_occupancy,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sag_pkg::BoardWidth-1:0] rsp_attack_set
);

   logic                gather_valid;
   logic                gather_ready;
   sag_pkg::gather_type gather_data;
   logic                scan_valid;
   logic                scan_ready;
   sag_pkg::scan_type   scan_data;

   sag_gather u_gather (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_command   (req_command),
      .in_square    (req_square),
      .in_occupancy (req_occupancy),
      .out_valid    (gather_valid),
      .out_ready    (gather_ready),
      .out_data     (gather_data)
   );

   sag_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gather_valid),
      .in_ready  (gather_ready),
      .in_data   (gather_data),
      .out_valid (scan_valid),
      .out_ready (scan_ready),
      .out_data  (scan_data)
   );

   sag_scatter u_scatter (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (scan_valid),
      .in_ready       (scan_ready),
      .in_data        (scan_data),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_attack_set (rsp_attack_set)
   );

endmodule

/* rtl/core/sag_gather.sv */
// First stage: collects board limits and occupancy along each of the four rays.
module sag_gather (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                in_command,
   input  logic [sag_pkg::SquareWidth-1:0]     in_square,
   input  logic [sag_pkg::BoardWidth-1:0]      in_occupancy,
   output logic                                out_valid,
   input  logic                                out_ready,
   output sag_pkg::gather_type                 out_data
);

   logic                valid_ff;
   logic                valid_in;
   sag_pkg::gather_type data_ff;
   sag_pkg::gather_type data_in;

   always_comb begin
      sag_pkg::ray_square_type sq;
      data_in.piece  = sag_pkg::piece_type'(in_command);
      data_in.square = in_square;
      for (int d = 0; d < sag_pkg::RayCount; d++) begin
         for (int k = 0; k < sag_pkg::RayLength; k++) begin
            sq = sag_pkg::ray_square(data_in.piece, sag_pkg::RayWidth'(d),
                                     sag_pkg::StepWidth'(k + 1), in_square);
            data_in.on_board[d][k] = sq.ok;
            data_in.occupied[d][k] = in_occupancy[sq.index];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/sag_scan.sv */
// Second stage: finds the squares each ray reaches before and including its first blocker.
module sag_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sag_pkg::gather_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sag_pkg::scan_type   out_data
);

   logic              valid_ff;
   logic              valid_in;
   sag_pkg::scan_type data_ff;
   sag_pkg::scan_type data_in;

   always_comb begin
      logic blocked;
      data_in.piece  = in_data.piece;
      data_in.square = in_data.square;
      for (int d = 0; d < sag_pkg::RayCount; d++) begin
         blocked = 1'b0;
         for (int k = 0; k < sag_pkg::RayLength; k++) begin
            data_in.reached[d][k] = in_data.on_board[d][k] && !blocked;
            blocked               = blocked || in_data.occupied[d][k];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/sag_scatter.sv */
// Final stage: maps reached ray squares back onto the board and holds the response.
module sag_scatter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  sag_pkg::scan_type              in_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [sag_pkg::BoardWidth-1:0] out_attack_set
);

   logic                           valid_ff;
   logic                           valid_in;
   logic [sag_pkg::BoardWidth-1:0] attack_ff;
   logic [sag_pkg::BoardWidth-1:0] attack_in;

   always_comb begin
      sag_pkg::ray_square_type sq;
      attack_in = '0;
      for (int d = 0; d < sag_pkg::RayCount; d++) begin
         for (int k = 0; k < sag_pkg::RayLength; k++) begin
            sq = sag_pkg::ray_square(in_data.piece, sag_pkg::RayWidth'(d),
                                     sag_pkg::StepWidth'(k + 1), in_data.square);
            if (in_data.reached[d][k]) begin
               attack_in[sq.index] = 1'b1;
            end
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         attack_ff <= attack_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_attack_set = attack_ff;

endmodule

/* rtl/core/sag_checker.sv */
// Port-level assertions for the sliding attack generator and the bind that attaches them.
module sag_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_command,
   input logic [sag_pkg::SquareWidth-1:0] req_square,
   input logic [sag_pkg::BoardWidth-1:0] req_occupancy,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sag_pkg::BoardWidth-1:0] rsp_attack_set
);

   logic unused_payload;
   assign unused_payload = req_command ^ (^req_square) ^ (^req_occupancy);

   // A stalled response keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_attack_set))
      else $error("stalled response changed or vanished");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // With the output register empty or draining, every stage can move on.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused although the pipeline can advance");

   // An unstalled request passes the gather, scan and scatter registers and then reaches the response port.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after three unstalled cycles");

endmodule

bind sliding_attack_generator sag_checker u_sag_checker (.*);
